/* sv/substring_first_last_matcher_assert.svh */
// Assertion macros for the substring matcher.
`ifndef SUBSTRING_FIRST_LAST_MATCHER_ASSERT_SVH
`define SUBSTRING_FIRST_LAST_MATCHER_ASSERT_SVH

`ifndef ASSERT_OFF
// Check a property on every clock edge outside reset.
`define SFLM_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Check a property on every clock edge, reset included.
`define SFLM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SFLM_ASSERT(lbl, clk, rst, prop, msg)
`define SFLM_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

/* sv/sflm_pkg.sv */
// Shared types, constants and helpers of the substring matcher.
package sflm_pkg;

   localparam int DEF_MAX_PATTERN   = 16;
   localparam int DEF_CHAR_BITS     = 8;
   localparam int DEF_POSITION_BITS = 16;

   localparam int OPCODE_BITS    = 2;
   localparam int CHAR_IN_BITS   = 8;
   localparam int INDEX_OUT_BITS = 16;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 1;
   localparam int FOLD_BITS      = 32;

   localparam logic [OPCODE_BITS-1:0] OP_CLEAR  = 2'd0;
   localparam logic [OPCODE_BITS-1:0] OP_APPEND = 2'd1;
   localparam logic [OPCODE_BITS-1:0] OP_TEXT   = 2'd2;
   localparam logic [OPCODE_BITS-1:0] OP_END    = 2'd3;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_CASE_INSENSITIVE = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FIND_LAST        = 2'd1;

   localparam logic [FOLD_BITS-1:0] LOWER_A    = 32'h61;
   localparam logic [FOLD_BITS-1:0] LOWER_Z    = 32'h7A;
   localparam logic [FOLD_BITS-1:0] CASE_DELTA = 32'h20;

   // Per-cell control, decoded once in the top level.
   typedef struct packed {
      logic load;    // write the pattern character into this cell
      logic shift;   // a text character arrives
      logic clear;   // drop the partial match
      logic fold;    // case-insensitive compare
      logic active;  // cell lies inside the current pattern
      logic last;    // cell holds the final pattern character
   } cell_ctrl_type;

   typedef struct packed {
      logic                      found;
      logic [INDEX_OUT_BITS-1:0] match_index;
      logic                      pattern_overflow;
      logic                      position_overflow;
   } rsp_type;

   // Fold ASCII a-z to A-Z when enabled.
   function automatic logic [FOLD_BITS-1:0] fold_char(input logic [FOLD_BITS-1:0] c,
                                                      input logic en);
      if (en && c >= LOWER_A && c <= LOWER_Z) begin
         return c - CASE_DELTA;
      end
      return c;
   endfunction

endpackage

/* sv/sflm_if.sv */
// Handshake channels of the substring matcher: request, response, register write.
interface sflm_req_if import sflm_pkg::*;;
   logic                    valid;
   logic                    ready;
   logic [OPCODE_BITS-1:0]  opcode;
   logic [CHAR_IN_BITS-1:0] char_value;
   modport source (output valid, output opcode, output char_value, input ready);
   modport sink   (input valid, input opcode, input char_value, output ready);
endinterface

interface sflm_rsp_if import sflm_pkg::*;;
   logic                      valid;
   logic                      ready;
   logic                      found;
   logic [INDEX_OUT_BITS-1:0] match_index;
   logic                      pattern_overflow;
   logic                      position_overflow;
   modport source (output valid, output found, output match_index,
                   output pattern_overflow, output position_overflow, input ready);
   modport sink   (input valid, input found, input match_index,
                   input pattern_overflow, input position_overflow, output ready);
endinterface

interface sflm_csr_if import sflm_pkg::*;;
   logic                      valid;
   logic                      ready;
   logic [CSR_INDEX_BITS-1:0] index;
   logic [CSR_DATA_BITS-1:0]  data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

/* sv/sflm_cell.sv */
// One pattern cell: a stored character and its partial-match bit.
module sflm_cell import sflm_pkg::*; #(
   parameter int CHAR_BITS = DEF_CHAR_BITS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  cell_ctrl_type        ctrl,
   input  logic [CHAR_BITS-1:0] load_char,
   input  logic [CHAR_BITS-1:0] text_char,   // already folded
   input  logic                 prev_match,
   output logic                 match,
   output logic                 tail_hit
);

   logic [CHAR_BITS-1:0] char_ff;
   logic                 match_ff;
   logic                 match_in;
   logic [FOLD_BITS-1:0] folded;
   logic                 equal;

   assign folded = fold_char(FOLD_BITS'(char_ff), ctrl.fold);
   assign equal  = (folded[CHAR_BITS-1:0] == text_char);

   always_comb begin
      match_in = match_ff;
      if (ctrl.clear) begin
         match_in = 1'b0;
      end else if (ctrl.shift) begin
         match_in = prev_match & equal & ctrl.active;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         match_ff <= 1'b0;
      end else begin
         match_ff <= match_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         char_ff <= load_char;
      end
   end

   assign match    = match_ff;
   assign tail_hit = match_in & ctrl.last & ctrl.shift;

endmodule

/* sv/substring_first_last_matcher.sv */
// Substring matcher top level: a chain of shift-and cells over a streamed text.
// One request per cycle sustained while the skid entry is empty; request ready drops while it is full.
// An end-of-text request registers its response in the main stage, or in the skid entry if a response is stalled.
// A two-entry response buffer keeps requests flowing while a response waits.
// Synchronous active-high reset clears the pattern length, search state and registers.
`include "substring_first_last_matcher_assert.svh"

module substring_first_last_matcher import sflm_pkg::*; #(
   parameter int MAX_PATTERN   = DEF_MAX_PATTERN,
   parameter int CHAR_BITS     = DEF_CHAR_BITS,
   parameter int POSITION_BITS = DEF_POSITION_BITS
) (
   input logic      clock,
   input logic      reset,
   sflm_req_if.sink req,
   sflm_rsp_if.source rsp,
   sflm_csr_if.sink csr
);

   localparam int LEN_BITS = $clog2(MAX_PATTERN + 1);

   // Configuration registers
   logic case_insensitive_ff;
   logic find_last_ff;

   // Pattern and search state
   logic [LEN_BITS-1:0]      len_ff;
   logic [POSITION_BITS-1:0] pos_ff;
   logic [POSITION_BITS-1:0] start_ff;
   logic                     seen_ff;
   logic                     dropped_ff;
   logic                     saturated_ff;

   // Response buffer: main stage plus one skid entry
   logic    rsp_valid_ff;
   logic    skid_valid_ff;
   rsp_type rsp_ff;
   rsp_type skid_ff;

   logic                     req_take;
   logic                     do_clear;
   logic                     do_append;
   logic                     do_text;
   logic                     do_end;
   logic                     store_full;
   logic [CHAR_BITS-1:0]     raw_char;
   logic [FOLD_BITS-1:0]     folded_text;
   logic [MAX_PATTERN-1:0]   match_bits;
   logic [MAX_PATTERN-1:0]   tail_bits;
   logic                     hit;
   logic [POSITION_BITS-1:0] start_here;
   logic                     rsp_pop;
   rsp_type                  result;

   // ---------------------------------------------------------------
   // Request decode
   // ---------------------------------------------------------------
   assign req.ready = !skid_valid_ff;
   assign req_take  = req.valid && req.ready;
   assign raw_char  = CHAR_BITS'(req.char_value);

   always_comb begin
      do_clear  = 1'b0;
      do_append = 1'b0;
      do_text   = 1'b0;
      do_end    = 1'b0;
      unique case (req.opcode)
         OP_CLEAR:  do_clear  = req_take;
         OP_APPEND: do_append = req_take;
         OP_TEXT:   do_text   = req_take;
         OP_END:    do_end    = req_take;
         default:   do_end    = 1'b0;
      endcase
   end

   assign store_full  = (len_ff >= LEN_BITS'(MAX_PATTERN));
   // Fold the text character once; every cell sees the same value.
   assign folded_text = fold_char(FOLD_BITS'(raw_char), case_insensitive_ff);

   // ---------------------------------------------------------------
   // Cell chain: cell i holds pattern character i and the bit saying
   // the last i+1 text characters matched pattern 0..i.
   // ---------------------------------------------------------------
   for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cell
      cell_ctrl_type ctrl;
      logic          prev_match;

      assign ctrl.load   = do_append && !store_full && (len_ff == LEN_BITS'(i));
      assign ctrl.shift  = do_text;
      assign ctrl.clear  = do_clear || do_end;
      assign ctrl.fold   = case_insensitive_ff;
      assign ctrl.active = (len_ff > LEN_BITS'(i));
      assign ctrl.last   = (len_ff == LEN_BITS'(i + 1));

      if (i == 0) begin : g_head
         // A new match may always begin at the current character.
         assign prev_match = 1'b1;
      end else begin : g_link
         assign prev_match = match_bits[i-1];
      end

      sflm_cell #(
         .CHAR_BITS (CHAR_BITS)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .load_char  (raw_char),
         .text_char  (folded_text[CHAR_BITS-1:0]),
         .prev_match (prev_match),
         .match      (match_bits[i]),
         .tail_hit   (tail_bits[i])
      );
   end

   // Full pattern matched at this text character.
   assign hit        = |tail_bits;
   assign start_here = pos_ff + POSITION_BITS'(1) - POSITION_BITS'(len_ff);

   // ---------------------------------------------------------------
   // Pattern length, overflow flag, position and recorded start
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff       <= '0;
         dropped_ff   <= 1'b0;
         pos_ff       <= '0;
         start_ff     <= '0;
         seen_ff      <= 1'b0;
         saturated_ff <= 1'b0;
      end else begin
         if (do_clear) begin
            len_ff     <= '0;
            dropped_ff <= 1'b0;
         end else if (do_append) begin
            if (store_full) begin
               dropped_ff <= 1'b1;   // drop the character, flag it
            end else begin
               len_ff <= len_ff + LEN_BITS'(1);
            end
         end

         if (do_clear || do_end) begin
            pos_ff       <= '0;
            start_ff     <= '0;
            seen_ff      <= 1'b0;
            saturated_ff <= 1'b0;
         end else if (do_text) begin
            if (hit) begin
               // Keep the first start unless the last one is wanted.
               if (find_last_ff || !seen_ff) begin
                  start_ff <= start_here;
               end
               seen_ff <= 1'b1;
            end
            if (&pos_ff) begin
               saturated_ff <= 1'b1;   // hold the count at its top
            end else begin
               pos_ff <= pos_ff + POSITION_BITS'(1);
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // Result of an end-of-text request
   // ---------------------------------------------------------------
   always_comb begin
      result.found             = 1'b0;
      result.match_index       = '0;
      result.pattern_overflow  = dropped_ff;
      result.position_overflow = saturated_ff;
      if (len_ff == '0) begin
         // Empty pattern matches at the start, or at the text end in last mode.
         result.found = 1'b1;
         if (find_last_ff) begin
            result.match_index = INDEX_OUT_BITS'(pos_ff);
         end
      end else if (seen_ff) begin
         result.found       = 1'b1;
         result.match_index = INDEX_OUT_BITS'(start_ff);
      end
   end

   // ---------------------------------------------------------------
   // Response buffer: a stalled response parks in the skid entry so
   // the request side stays open for one more end-of-text.
   // ---------------------------------------------------------------
   assign rsp_pop = rsp_valid_ff && rsp.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (skid_valid_ff) begin
            if (rsp_pop) begin
               skid_valid_ff <= 1'b0;   // advance skid into the main stage
            end
         end else if (do_end) begin
            if (rsp_valid_ff && !rsp_pop) begin
               skid_valid_ff <= 1'b1;
            end else begin
               rsp_valid_ff <= 1'b1;
            end
         end else if (rsp_pop) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (rsp_pop) begin
            rsp_ff <= skid_ff;
         end
      end else if (do_end) begin
         if (rsp_valid_ff && !rsp_pop) begin
            skid_ff <= result;
         end else begin
            rsp_ff <= result;
         end
      end
   end

   assign rsp.valid             = rsp_valid_ff;
   assign rsp.found             = rsp_ff.found;
   assign rsp.match_index       = rsp_ff.match_index;
   assign rsp.pattern_overflow  = rsp_ff.pattern_overflow;
   assign rsp.position_overflow = rsp_ff.position_overflow;

   // ---------------------------------------------------------------
   // Register writes: always ready; unknown indexes are ignored.
   // ---------------------------------------------------------------
   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         case_insensitive_ff <= 1'b0;
         find_last_ff        <= 1'b0;
      end else if (csr.valid && csr.ready) begin
         unique case (csr.index)
            CSR_CASE_INSENSITIVE: case_insensitive_ff <= csr.data[0];
            CSR_FIND_LAST:        find_last_ff        <= csr.data[0];
            default:              find_last_ff        <= find_last_ff;
         endcase
      end
   end

   // ---------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------
   `SFLM_ASSERT(a_skid_behind_main, clock, reset, skid_valid_ff |-> rsp_valid_ff, "skid entry filled while main stage empty")
   `SFLM_ASSERT(a_len_in_range, clock, reset, len_ff <= LEN_BITS'(MAX_PATTERN), "pattern length beyond store size")
   `SFLM_ASSERT(a_end_gives_rsp, clock, reset, do_end |=> rsp_valid_ff, "end of text did not produce a response")
   `SFLM_ASSERT(a_sat_at_top, clock, reset, saturated_ff |-> (&pos_ff), "saturation flag set below the top count")

endmodule

/* tb/tb_substring_first_last_matcher.sv */
// Testbench of the substring matcher: queued request stream, shift-and predictor, response check.
`timescale 1ns / 100ps

module tb_substring_first_last_matcher import sflm_pkg::*;;

   localparam int MAX_PAT       = DEF_MAX_PATTERN;
   localparam int POS_W         = DEF_POSITION_BITS;
   localparam int CYCLE_LIMIT   = 2_000_000;
   localparam int SETTLE_CYCLES = 6;
   localparam int RANDOM_PHASES = 12;
   localparam int PHASE_ITEMS   = 105;

   localparam logic [7:0] ASCII_UC_A = 8'h41;
   localparam logic [7:0] ASCII_UC_Z = 8'h5A;
   localparam logic [7:0] ASCII_LC_A = 8'h61;
   localparam logic [7:0] ASCII_LC_Z = 8'h7A;
   localparam logic [7:0] CASE_BIT   = 8'h20;

   typedef struct packed {
      logic [OPCODE_BITS-1:0]  opcode;
      logic [CHAR_IN_BITS-1:0] char_value;
   } request_type;

   logic clock;
   logic reset;

   sflm_req_if req_ch ();
   sflm_rsp_if rsp_ch ();
   sflm_csr_if csr_ch ();

   substring_first_last_matcher u_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch),
      .csr   (csr_ch)
   );

   // Requests waiting to be driven, and match reports the block still owes us.
   request_type request_q[$];
   rsp_type     report_due_q[$];
   request_type next_req;
   rsp_type     got_rsp;
   rsp_type     want_rsp;

   int issued_count;
   int accepted_count;
   int err_count;
   int cycle_count;
   int send_gap;
   int stall_left;
   bit no_gaps;

   // Shadow of the matcher: pattern, search state and register settings.
   logic [7:0]         pat_chars [MAX_PAT];
   logic [4:0]         pat_len;
   logic [MAX_PAT-1:0] partial;
   logic [POS_W-1:0]   text_pos;
   logic [POS_W-1:0]   start_rec;
   bit                 seen;
   bit                 pat_dropped;
   bit                 pos_sat;
   bit                 fold_on;
   bit                 find_last_on;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------

   function automatic logic [7:0] fold_ascii(input logic [7:0] c);
      // only a-z fold; punctuation right next to the letters stays as is
      if (fold_on && c >= ASCII_LC_A && c <= ASCII_LC_Z) begin
         return c & ~CASE_BIT;
      end
      return c;
   endfunction

   function automatic void clear_search_state();
      partial   = '0;
      text_pos  = '0;
      seen      = 1'b0;
      start_rec = '0;
      pos_sat   = 1'b0;
   endfunction

   function automatic void match_step(input logic [OPCODE_BITS-1:0]  op,
                                      input logic [CHAR_IN_BITS-1:0] ch);
      logic [MAX_PAT-1:0] eq_bits;
      logic [MAX_PAT-1:0] len_mask;
      logic [7:0]         ch_f;
      rsp_type            rpt;
      eq_bits = '0;
      ch_f    = fold_ascii(ch);
      case (op)
         OP_CLEAR: begin
            pat_len     = '0;
            pat_dropped = 1'b0;
            clear_search_state();
         end
         OP_APPEND: begin
            // a full store drops the character and flags it until the next clear
            if (pat_len < MAX_PAT) begin
               pat_chars[pat_len] = ch;
               pat_len++;
            end else begin
               pat_dropped = 1'b1;
            end
         end
         OP_TEXT: begin
            for (int i = 0; i < MAX_PAT; i++) begin
               if (i < pat_len && fold_ascii(pat_chars[i]) == ch_f) begin
                  eq_bits[i] = 1'b1;
               end
            end
            len_mask = (pat_len >= MAX_PAT) ? '1 : MAX_PAT'((32'd1 << pat_len) - 1);
            partial  = ((partial << 1) | MAX_PAT'(1)) & eq_bits & len_mask;
            if (pat_len != 0 && partial[pat_len - 1]) begin
               // start wraps in position width; after saturation it is unreliable
               if (find_last_on || !seen) begin
                  start_rec = text_pos + POS_W'(1) - POS_W'(pat_len);
               end
               seen = 1'b1;
            end
            if (text_pos == '1) begin
               pos_sat = 1'b1;
            end else begin
               text_pos++;
            end
         end
         default: begin
            rpt = '0;
            if (pat_len == 0) begin
               rpt.found       = 1'b1;
               rpt.match_index = find_last_on ? INDEX_OUT_BITS'(text_pos) : '0;
            end else if (seen) begin
               rpt.found       = 1'b1;
               rpt.match_index = INDEX_OUT_BITS'(start_rec);
            end
            rpt.pattern_overflow  = pat_dropped;
            rpt.position_overflow = pos_sat;
            report_due_q.push_back(rpt);
            clear_search_state();
         end
      endcase
   endfunction

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------

   // Mostly no gap, some short ones, a few long ones.
   function automatic int next_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_gaps || r < 60) begin
         return 0;
      end
      if (r < 90) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 30);
   endfunction

   function automatic void add_item(input logic [OPCODE_BITS-1:0]  op,
                                    input logic [CHAR_IN_BITS-1:0] ch);
      request_type it;
      it.opcode     = op;
      it.char_value = ch;
      request_q.push_back(it);
      issued_count++;
   endfunction

   // Small alphabet so matches are common; the rest probes the fold edges and all codes.
   function automatic logic [7:0] pick_char();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) begin
         case ($urandom_range(0, 3))
            0:       return ASCII_UC_A;
            1:       return ASCII_UC_A + 8'd1;
            2:       return ASCII_LC_A;
            default: return ASCII_LC_A + 8'd1;
         endcase
      end
      if (r < 85) begin
         return 8'($urandom_range(8'h3F, 8'h7C));
      end
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic logic [7:0] case_flip(input logic [7:0] c);
      if (((c >= ASCII_UC_A && c <= ASCII_UC_Z) || (c >= ASCII_LC_A && c <= ASCII_LC_Z))
          && $urandom_range(0, 1) == 1) begin
         return c ^ CASE_BIT;
      end
      return c;
   endfunction

   // One search: optional clear, pattern load, text with planted copies, end of text.
   task automatic add_search();
      logic [7:0] pat[$];
      logic [7:0] c;
      int         r;
      int         plen;
      int         tlen;
      int         n;
      if ($urandom_range(0, 9) < 7) begin
         add_item(OP_CLEAR, 8'($urandom_range(0, 255)));
      end
      r = $urandom_range(0, 99);
      plen = (r < 10) ? 0 : (r < 88) ? $urandom_range(1, 4) : $urandom_range(14, 18);
      for (int k = 0; k < plen; k++) begin
         c = pick_char();
         pat.push_back(c);
         add_item(OP_APPEND, c);
      end
      tlen = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(0, 24);
      n = 0;
      while (n < tlen) begin
         if (pat.size() != 0 && $urandom_range(0, 3) == 0) begin
            foreach (pat[k]) begin
               add_item(OP_TEXT, case_flip(pat[k]));
            end
            n += pat.size();
         end else begin
            add_item(OP_TEXT, pick_char());
            n++;
         end
         // grow the pattern in the middle of a text now and then
         if ($urandom_range(0, 49) == 0) begin
            add_item(OP_APPEND, pick_char());
         end
      end
      add_item(OP_END, 8'($urandom_range(0, 255)));
   endtask

   // Hold the sender until every owed report is in, then let the block settle.
   task automatic drain();
      while (accepted_count != issued_count || report_due_q.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0]  val);
      @(posedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= val;
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
      if (idx == CSR_CASE_INSENSITIVE) begin
         fold_on = val[0];
      end else if (idx == CSR_FIND_LAST) begin
         find_last_on = val[0];
      end
   endtask

   task automatic set_mode(input bit fold, input bit last);
      write_reg(CSR_CASE_INSENSITIVE, fold);
      write_reg(CSR_FIND_LAST, last);
   endtask

   // ------------------------------------------------------------------
   // Request driver: advance on each accepted request, insert random gaps
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         send_gap = 0;
      end else begin
         // a request taken at this edge updates the shadow state
         if (req_ch.valid && req_ch.ready) begin
            match_step(req_ch.opcode, req_ch.char_value);
            accepted_count++;
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_ch.valid <= 1'b0;
            end else if (request_q.size() != 0) begin
               next_req = request_q.pop_front();
               req_ch.valid      <= 1'b1;
               req_ch.opcode     <= next_req.opcode;
               req_ch.char_value <= next_req.char_value;
               send_gap = next_gap();
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Response monitor: compare each report with the oldest one owed
   // ------------------------------------------------------------------

   function automatic void check_field(input string name, input logic [15:0] want,
                                       input logic [15:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
         err_count++;
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            got_rsp.found             = rsp_ch.found;
            got_rsp.match_index       = rsp_ch.match_index;
            got_rsp.pattern_overflow  = rsp_ch.pattern_overflow;
            got_rsp.position_overflow = rsp_ch.position_overflow;
            if (report_due_q.size() == 0) begin
               $display("%0t: response with none owed: expected nothing, actual %p",
                        $time, got_rsp);
               err_count++;
            end else begin
               want_rsp = report_due_q.pop_front();
               check_field("found", want_rsp.found, got_rsp.found);
               check_field("match_index", want_rsp.match_index, got_rsp.match_index);
               check_field("pattern_overflow", want_rsp.pattern_overflow,
                           got_rsp.pattern_overflow);
               check_field("position_overflow", want_rsp.position_overflow,
                           got_rsp.position_overflow);
            end
         end
         // drop ready for a random stretch, independent of valid
         if (no_gaps) begin
            rsp_ch.ready <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
            stall_left = next_gap();
         end
      end
   end

   // ------------------------------------------------------------------
   // Watchdog
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d reports still owed", $time, report_due_q.size());
         $display("*** FAILED ***");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Stimulus sequence
   // ------------------------------------------------------------------
   initial begin
      bit fold;
      bit last;
      int target;

      // drive every input to a known value before the first edge
      reset             = 1'b1;
      req_ch.valid      = 1'b0;
      req_ch.opcode     = OP_CLEAR;
      req_ch.char_value = '0;
      rsp_ch.ready      = 1'b0;
      csr_ch.valid      = 1'b0;
      csr_ch.index      = CSR_CASE_INSENSITIVE;
      csr_ch.data       = '0;
      issued_count      = 0;
      accepted_count    = 0;
      err_count         = 0;
      cycle_count       = 0;
      no_gaps           = 1'b0;
      fold_on           = 1'b0;
      find_last_on      = 1'b0;
      pat_len           = '0;
      pat_dropped       = 1'b0;
      clear_search_state();
      foreach (pat_chars[k]) pat_chars[k] = '0;

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part, registers at their reset values (exact, first occurrence).
      // Empty pattern over an empty text, then over a short text.
      add_item(OP_END, 8'hFF);
      add_item(OP_TEXT, 8'h00);
      add_item(OP_TEXT, 8'hFF);
      add_item(OP_END, 8'h00);
      // Extreme character codes in pattern and text; first hit is at index 1.
      add_item(OP_APPEND, 8'h00);
      add_item(OP_APPEND, 8'hFF);
      add_item(OP_TEXT, 8'hFF);
      add_item(OP_TEXT, 8'h00);
      add_item(OP_TEXT, 8'hFF);
      add_item(OP_END, 8'h55);
      // Pattern longer than the text: no hit.
      add_item(OP_CLEAR, 8'hAA);
      add_item(OP_APPEND, ASCII_LC_A);
      add_item(OP_APPEND, ASCII_LC_Z);
      add_item(OP_APPEND, 8'h7B);
      add_item(OP_TEXT, ASCII_LC_A);
      add_item(OP_TEXT, ASCII_LC_Z);
      add_item(OP_END, 8'h00);
      // Upper case text against a lower case pattern, exact mode: no hit.
      add_item(OP_TEXT, ASCII_UC_A);
      add_item(OP_TEXT, ASCII_UC_Z);
      add_item(OP_TEXT, 8'h7B);
      add_item(OP_END, 8'hFF);
      drain();

      // Full pattern store: the seventeenth character is dropped and flagged.
      set_mode(1'b1, 1'b1);
      add_item(OP_CLEAR, 8'h00);
      repeat (MAX_PAT + 1) add_item(OP_APPEND, ASCII_LC_A);
      repeat (MAX_PAT + 2) add_item(OP_TEXT, ASCII_UC_A);
      add_item(OP_END, 8'h3C);
      // pattern and drop flag survive end of text
      repeat (MAX_PAT) add_item(OP_TEXT, ASCII_LC_A);
      add_item(OP_END, 8'hC3);
      // empty pattern in last mode reports the text length
      add_item(OP_CLEAR, 8'hFF);
      add_item(OP_TEXT, ASCII_LC_Z);
      add_item(OP_END, 8'h00);
      drain();

      // Random phases: the four corner settings first, then random ones.
      // Each phase ends with the sender held until all reports are in,
      // sometimes mid-text so the new settings apply to a running search.
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         case (ph)
            0:       begin fold = 1'b0; last = 1'b0; end
            1:       begin fold = 1'b1; last = 1'b1; end
            2:       begin fold = 1'b0; last = 1'b1; end
            3:       begin fold = 1'b1; last = 1'b0; end
            default: begin fold = $urandom_range(0, 1); last = $urandom_range(0, 1); end
         endcase
         set_mode(fold, last);
         no_gaps = (ph % 5 == 2);
         target  = issued_count + PHASE_ITEMS;
         while (issued_count < target) begin
            if ($urandom_range(0, 99) < 85) begin
               add_search();
            end else begin
               add_item(OP_BITS_RAND(), 8'($urandom_range(0, 255)));
            end
         end
         if ($urandom_range(0, 1) == 1) begin
            repeat ($urandom_range(1, 3)) add_item(OP_TEXT, pick_char());
         end
         drain();
      end
      no_gaps = 1'b0;

      // close any text left open by the last phase
      add_item(OP_END, 8'($urandom_range(0, 255)));
      drain();

      if (err_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   // Any opcode at all, for the noise between well-formed searches.
   function automatic logic [OPCODE_BITS-1:0] OP_BITS_RAND();
      case ($urandom_range(0, 3))
         0:       return OP_CLEAR;
         1:       return OP_APPEND;
         2:       return OP_TEXT;
         default: return OP_END;
      endcase
   endfunction

endmodule

/* files.f */
+incdir+sv
sv/sflm_pkg.sv
sv/sflm_if.sv
sv/sflm_cell.sv
sv/substring_first_last_matcher.sv
tb/tb_substring_first_last_matcher.sv
